### rtl/core/rpu_pkg.sv
// shared types and constants of the raw10 pixel unpacker
package rpu_pkg;

  // settings limits checked at the start of each frame
  localparam logic [12:0] MAX_WIDTH  = 13'd4096;
  localparam logic [12:0] MAX_HEIGHT = 13'd4096;
  localparam logic [13:0] MAX_STRIDE = 14'd8192;

  // number of result records one byte can cause
  localparam int unsigned MaxRecs = 5;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PACKED_MODE  = 2'd0,
    CFG_LINE_WIDTH   = 2'd1,
    CFG_FRAME_HEIGHT = 2'd2,
    CFG_LINE_STRIDE  = 2'd3
  } cfg_idx_e;

  // status codes of a status record
  typedef enum logic [2:0] {
    ST_NONE   = 3'd0,
    ST_DONE   = 3'd1,
    ST_STRIDE = 3'd2,
    ST_WIDTH  = 3'd3,
    ST_BUFFER = 3'd4
  } status_e;

  // frame tracking state
  typedef enum logic [2:0] {
    FS_ACTIVE = 3'b001,
    FS_DROP   = 3'b010,
    FS_DONE   = 3'b100
  } frame_e;

  typedef struct packed {
    logic        packed_mode;
    logic [12:0] line_width;
    logic [12:0] frame_height;
    logic [13:0] line_stride;
  } cfg_t;

  typedef struct packed {
    logic        is_pixel;
    logic [15:0] pixel_value;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    status_e     status;
  } rec_t;

  // the records caused by one byte
  typedef struct packed {
    logic [2:0]             cnt;
    rec_t [MaxRecs-1:0]     recs;
  } grp_t;

  // handoff between the decode core and the output sequencer
  typedef struct packed {
    logic load;
    grp_t grp;
  } grp_push_t;

endpackage

### rtl/core/rpu_cfg_regs.sv
// configuration registers of the raw10 pixel unpacker
module rpu_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [13:0]    cfg_data_i,
  output rpu_pkg::cfg_t  cfg_o
);
  import rpu_pkg::*;

  cfg_t cfg_q;

  // register writes by index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packed_mode  <= 1'b1;
      cfg_q.line_width   <= 13'd1920;
      cfg_q.frame_height <= 13'd1080;
      cfg_q.line_stride  <= 14'd2400;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PACKED_MODE:  cfg_q.packed_mode  <= cfg_data_i[0];
        CFG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data_i[12:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[12:0];
        CFG_LINE_STRIDE:  cfg_q.line_stride  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/rpu_in_stage.sv
// input register holding one accepted byte until the core consumes it
module rpu_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // buffer_end
  input  logic       adv_i,
  output logic       vld_o,
  output logic [7:0] byte_o,
  output logic       end_o
);
  logic       vld_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       take;

  assign s_axis_tready = !vld_q || adv_i;
  assign take          = s_axis_tvalid && s_axis_tready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (adv_i) begin
      vld_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= s_axis_tdata;
      end_q  <= s_axis_tlast;
    end
  end

  assign vld_o  = vld_q;
  assign byte_o = byte_q;
  assign end_o  = end_q;

endmodule

### rtl/core/rpu_core.sv
// frame counters, settings check and pixel assembly for one byte
module rpu_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpu_pkg::cfg_t       cfg_i,
  input  logic                vld_i,
  input  logic [7:0]          byte_i,
  input  logic                end_i,
  input  logic                out_free_i,
  output logic                adv_o,
  output rpu_pkg::grp_push_t  push_o
);
  import rpu_pkg::*;

  logic [13:0] bil_q, bil_d;
  logic [12:0] lc_q, lc_d;
  logic [12:0] col_q, col_d;
  logic [2:0]  phase_q, phase_d;
  frame_e      fs_q, fs_d;
  logic [7:0]  held_q [4];
  logic [7:0]  held_d [4];

  status_e     err;
  logic        err_hit;
  logic [15:0] pack_min;
  logic [13:0] needed;
  logic [14:0] bil_inc;
  logic [12:0] lc_inc;
  logic [2:0]  npix;
  status_e     tail;
  rec_t        pix [4];
  grp_t        grp;

  // settings check
  always_comb begin
    pack_min = (16'(cfg_i.line_width) * 16'd5 + 16'd3) >> 2;
    err      = ST_NONE;
    if (cfg_i.line_width == '0 || cfg_i.line_width > MAX_WIDTH ||
        cfg_i.frame_height == '0 || cfg_i.frame_height > MAX_HEIGHT ||
        cfg_i.line_stride == '0 || cfg_i.line_stride > MAX_STRIDE) begin
      err = ST_STRIDE;
    end else if (cfg_i.packed_mode) begin
      if (16'(cfg_i.line_stride) < pack_min) begin
        err = ST_STRIDE;
      end else if (cfg_i.line_width[1:0] != 2'b00) begin
        err = ST_WIDTH;
      end
    end else if (cfg_i.line_stride < {cfg_i.line_width, 1'b0}) begin
      err = ST_STRIDE;
    end
  end

  assign err_hit = (fs_q == FS_ACTIVE) && (bil_q == '0) && (lc_q == '0) &&
                   (err != ST_NONE);
  assign needed  = cfg_i.packed_mode ?
                   14'({cfg_i.line_width[12:2], 2'b00}) + 14'(cfg_i.line_width[12:2])
                   : {cfg_i.line_width, 1'b0};
  assign bil_inc = 15'(bil_q) + 15'd1;
  assign lc_inc  = lc_q + 13'd1;

  // candidate pixel records
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pix[k].is_pixel     = 1'b1;
      pix[k].pixel_row    = lc_q[11:0];
      pix[k].pixel_column = col_q[11:0] + 12'(k);
      pix[k].status       = ST_NONE;
      if (cfg_i.packed_mode) begin
        pix[k].pixel_value = {6'd0, held_q[k], byte_i[2*k +: 2]};
      end else begin
        pix[k].pixel_value = {byte_i, held_q[0]};
      end
    end
  end

  // next state and record count
  always_comb begin
    bil_d   = bil_q;
    lc_d    = lc_q;
    col_d   = col_q;
    phase_d = phase_q;
    fs_d    = fs_q;
    for (int k = 0; k < 4; k++) begin
      held_d[k] = held_q[k];
    end
    npix = 3'd0;
    tail = ST_NONE;

    if (err_hit) begin
      fs_d = FS_DROP;
    end else if (fs_q == FS_ACTIVE) begin
      if (15'(bil_q) < 15'(needed)) begin
        if (cfg_i.packed_mode) begin
          if (phase_q < 3'd4) begin
            held_d[phase_q[1:0]] = byte_i;
            phase_d              = phase_q + 3'd1;
          end else begin
            npix    = 3'd4;
            col_d   = col_q + 13'd4;
            phase_d = 3'd0;
          end
        end else begin
          if (phase_q == 3'd0) begin
            held_d[0] = byte_i;
            phase_d   = 3'd1;
          end else begin
            npix    = 3'd1;
            col_d   = col_q + 13'd1;
            phase_d = 3'd0;
          end
        end
      end
      // line end after stride bytes
      if (bil_inc >= 15'(cfg_i.line_stride)) begin
        bil_d   = '0;
        col_d   = '0;
        phase_d = '0;
        lc_d    = lc_inc;
        if (lc_inc >= cfg_i.frame_height) begin
          tail = ST_DONE;
          fs_d = FS_DONE;
        end
      end else begin
        bil_d = bil_inc[13:0];
      end
    end

    // end of the supplied buffer starts a new frame
    if (end_i) begin
      if (fs_d == FS_ACTIVE) begin
        tail = ST_BUFFER;
      end
      bil_d   = '0;
      lc_d    = '0;
      col_d   = '0;
      phase_d = '0;
      fs_d    = FS_ACTIVE;
    end
  end

  // record group
  always_comb begin
    grp = '0;
    if (err_hit) begin
      grp.cnt              = 3'd1;
      grp.recs[0].status   = err;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < npix) begin
          grp.recs[k] = pix[k];
        end
      end
      grp.cnt = npix + ((tail != ST_NONE) ? 3'd1 : 3'd0);
      if (tail != ST_NONE) begin
        case (npix)
          3'd0:    grp.recs[0].status = tail;
          3'd1:    grp.recs[1].status = tail;
          default: grp.recs[4].status = tail;
        endcase
      end
    end
  end

  assign adv_o       = vld_i && ((grp.cnt == 3'd0) || out_free_i);
  assign push_o.load = adv_o && (grp.cnt != 3'd0);
  assign push_o.grp  = grp;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bil_q   <= '0;
      lc_q    <= '0;
      col_q   <= '0;
      phase_q <= '0;
      fs_q    <= FS_ACTIVE;
    end else if (adv_o) begin
      bil_q   <= bil_d;
      lc_q    <= lc_d;
      col_q   <= col_d;
      phase_q <= phase_d;
      fs_q    <= fs_d;
    end
  end

  // held bytes of the current group
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      for (int k = 0; k < 4; k++) begin
        held_q[k] <= held_d[k];
      end
    end
  end

endmodule

### rtl/core/rpu_out_seq.sv
// result register that hands out the records of one byte one word at a time
module rpu_out_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rpu_pkg::grp_push_t  push_i,
  output logic                out_free_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata,   // [15:0] pixel_value, [27:16] pixel_column,
                                              // [39:28] pixel_row, [42:40] status, rest zero
  output logic                m_axis_tuser,   // is_pixel
  output logic                m_axis_tlast    // last_of_run
);
  import rpu_pkg::*;

  logic       vld_q;
  logic [2:0] idx_q;
  grp_t       grp_q;
  rec_t       rec;
  logic       last;
  logic       fire;

  assign rec        = grp_q.recs[idx_q];
  assign last       = (idx_q == grp_q.cnt - 3'd1);
  assign fire       = vld_q && m_axis_tready;
  assign out_free_o = !vld_q || (fire && last);

  // valid flag and record index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (push_i.load) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (fire) begin
      if (last) begin
        vld_q <= 1'b0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + 3'd1;
      end
    end
  end

  // record group payload
  always_ff @(posedge clk_i) begin
    if (push_i.load) begin
      grp_q <= push_i.grp;
    end
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata  = {5'd0, rec.status, rec.pixel_row, rec.pixel_column,
                          rec.pixel_value};
  assign m_axis_tuser  = rec.is_pixel;
  assign m_axis_tlast  = last;

endmodule

### rtl/core/raw10_pixel_unpacker_top.sv
// top level of the raw10 pixel unpacker
// The slave stream takes one frame byte per word (tlast marks the end of the
// supplied buffer). The master stream gives one record per word: a pixel with
// its column and row, or a status record (frame done, bad stride, width not a
// multiple of four, buffer too small); tuser is set on pixels and tlast on
// the final record caused by one input byte.
// The user must write settings through cfg_we_i/cfg_idx_i/cfg_data_i only
// while no byte is in flight; the block does not enforce this. They are
// checked on the first byte of each frame. A byte is accepted every cycle; a
// byte that causes records waits while the result register still holds
// records of an earlier byte, since that register sends one record per cycle
// while the receiver is ready. A packed group of five bytes gives four
// pixels, so a steady packed stream runs at one byte a cycle. Reset restores
// the default settings and starts a new frame at the next byte. When the
// receiver stalls, the result register holds its record and the input
// register fills, after which tready on the slave side drops.
module raw10_pixel_unpacker_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [13:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // buffer_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [15:0] pixel_value, [27:16] pixel_column,
                                      // [39:28] pixel_row, [42:40] status, rest zero
  output logic        m_axis_tuser,   // is_pixel
  output logic        m_axis_tlast    // last_of_run
);
  import rpu_pkg::*;

  cfg_t      cfg;
  logic      in_vld;
  logic [7:0] in_byte;
  logic      in_end;
  logic      adv;
  logic      out_free;
  grp_push_t push;

  // settings
  rpu_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  rpu_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .adv_i         (adv),
    .vld_o         (in_vld),
    .byte_o        (in_byte),
    .end_o         (in_end)
  );

  // decode
  rpu_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .vld_i      (in_vld),
    .byte_i     (in_byte),
    .end_i      (in_end),
    .out_free_i (out_free),
    .adv_o      (adv),
    .push_o     (push)
  );

  // result register and record sequencing
  rpu_out_seq u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .out_free_o    (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/raw10_pixel_unpacker_top_tb.sv
// self-checking testbench of the raw10 pixel unpacker: random frames in, records checked
module raw10_pixel_unpacker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpu_pkg::*;

  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned RandomBytes = 360;

  // one word of the byte stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  // one predicted record
  typedef struct packed {
    logic        is_pixel;
    logic [15:0] value;
    logic [11:0] column;
    logic [11:0] row;
    status_e     status;
    logic        last;
  } pix_rec_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = '0;
  logic [13:0] cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  in_word_t    byte_q[$];
  pix_rec_t    rec_q[$];
  logic        no_idle      = 1'b0;
  int          n_errors     = 0;
  int unsigned stall_cycles = 0;

  // shadow settings and decode state of the unpacker
  logic        sh_packed = 1'b1;
  int unsigned sh_width  = 1920;
  int unsigned sh_height = 1080;
  int unsigned sh_stride = 2400;
  int unsigned sh_byte_in_line = 0;
  int unsigned sh_line  = 0;
  int unsigned sh_col   = 0;
  int unsigned sh_phase = 0;
  logic [7:0]  sh_held[4] = '{default: 8'h00};
  frame_e      sh_state = FS_ACTIVE;

  raw10_pixel_unpacker_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
    n_errors++;
    $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
  endtask

  function automatic pix_rec_t status_rec(status_e st);
    pix_rec_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic pix_rec_t pixel_rec(logic [15:0] v);
    pix_rec_t r;
    r = '0;
    r.is_pixel = 1'b1;
    r.value    = v;
    r.column   = sh_col[11:0];
    r.row      = sh_line[11:0];
    return r;
  endfunction

  // settings check made on the first byte of a frame
  function automatic status_e settings_status();
    if (sh_width == 0 || sh_width > MAX_WIDTH || sh_height == 0 || sh_height > MAX_HEIGHT ||
        sh_stride == 0 || sh_stride > MAX_STRIDE) begin
      return ST_STRIDE;
    end
    if (sh_packed) begin
      if (sh_stride < (sh_width * 5 + 3) / 4) return ST_STRIDE;
      if (sh_width % 4 != 0) return ST_WIDTH;
    end else if (sh_stride < sh_width * 2) begin
      return ST_STRIDE;
    end
    return ST_NONE;
  endfunction

  // records caused by one accepted byte
  function automatic void decode_byte(logic [7:0] b, logic close);
    pix_rec_t    recs[$];
    status_e     err;
    int unsigned need;
    if (sh_state == FS_ACTIVE && sh_byte_in_line == 0 && sh_line == 0) begin
      err = settings_status();
      if (err != ST_NONE) begin
        recs.insert(recs.size(), status_rec(err));
        sh_state = FS_DROP;
      end
    end
    if (sh_state == FS_ACTIVE) begin
      need = sh_packed ? (sh_width / 4) * 5 : sh_width * 2;
      if (sh_byte_in_line < need) begin
        if (sh_packed) begin
          if (sh_phase < 4) begin
            sh_held[sh_phase] = b;
            sh_phase++;
          end else begin
            // fifth byte holds the two low bits of each pixel
            for (int k = 0; k < 4; k++) begin
              recs.insert(recs.size(), pixel_rec({6'd0, sh_held[k], 2'(b >> (2 * k))}));
              sh_col = (sh_col + 1) & 32'h1FFF;
            end
            sh_phase = 0;
          end
        end else if (sh_phase == 0) begin
          sh_held[0] = b;
          sh_phase   = 1;
        end else begin
          recs.insert(recs.size(), pixel_rec({b, sh_held[0]}));
          sh_col   = (sh_col + 1) & 32'h1FFF;
          sh_phase = 0;
        end
      end
      // end of line after the stride, end of frame after the last line
      sh_byte_in_line++;
      if (sh_byte_in_line >= sh_stride) begin
        sh_byte_in_line = 0;
        sh_col   = 0;
        sh_phase = 0;
        sh_line  = (sh_line + 1) & 32'h1FFF;
        if (sh_line >= sh_height) begin
          recs.insert(recs.size(), status_rec(ST_DONE));
          sh_state = FS_DONE;
        end
      end
    end
    if (close) begin
      if (sh_state == FS_ACTIVE) recs.insert(recs.size(), status_rec(ST_BUFFER));
      sh_byte_in_line = 0;
      sh_line  = 0;
      sh_col   = 0;
      sh_phase = 0;
      sh_state = FS_ACTIVE;
    end
    if (recs.size() != 0) recs[recs.size() - 1].last = 1'b1;
    foreach (recs[i]) rec_q.insert(rec_q.size(), recs[i]);
  endfunction

  // byte driver
  always @(posedge clk_i) begin : drive_bytes
    in_word_t nxt;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      decode_byte(s_axis_tdata, s_axis_tlast);
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (rst_ni && byte_q.size() != 0 && (no_idle || $urandom_range(99) >= 31)) begin
        nxt = byte_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= nxt.data;
        s_axis_tlast  <= nxt.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // record monitor and receiver stalls
  always @(posedge clk_i) begin : check_recs
    pix_rec_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rec_q.size() == 0) begin
        report_mismatch("record with none expected", 0, m_axis_tdata);
      end else begin
        e = rec_q.pop_front();
        if (m_axis_tuser !== e.is_pixel) report_mismatch("is_pixel", e.is_pixel, m_axis_tuser);
        if (m_axis_tdata[15:0] !== e.value) begin
          report_mismatch("pixel_value", e.value, m_axis_tdata[15:0]);
        end
        if (m_axis_tdata[27:16] !== e.column) begin
          report_mismatch("pixel_column", e.column, m_axis_tdata[27:16]);
        end
        if (m_axis_tdata[39:28] !== e.row) begin
          report_mismatch("pixel_row", e.row, m_axis_tdata[39:28]);
        end
        if (m_axis_tdata[42:40] !== e.status) begin
          report_mismatch("status", e.status, m_axis_tdata[42:40]);
        end
        if (m_axis_tdata[47:43] !== 5'd0) report_mismatch("tdata fill", 0, m_axis_tdata[47:43]);
        if (m_axis_tlast !== e.last) report_mismatch("last_of_run", e.last, m_axis_tlast);
      end
    end
    m_axis_tready <= no_idle || ($urandom_range(99) >= 31);
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // register write, enable left high for a following write
  task automatic cfg_write(cfg_idx_e idx, logic [13:0] d);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    case (idx)
      CFG_PACKED_MODE:  sh_packed = d[0];
      CFG_LINE_WIDTH:   sh_width  = d[12:0];
      CFG_FRAME_HEIGHT: sh_height = d[12:0];
      CFG_LINE_STRIDE:  sh_stride = d;
      default: ;
    endcase
  endtask

  // all four registers, unused high bits random
  task automatic set_config(logic pk, int unsigned w, int unsigned h, int unsigned s);
    cfg_write(CFG_PACKED_MODE, {13'($urandom), pk});
    cfg_write(CFG_LINE_WIDTH, {1'($urandom), w[12:0]});
    cfg_write(CFG_FRAME_HEIGHT, {1'($urandom), h[12:0]});
    cfg_write(CFG_LINE_STRIDE, s[13:0]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every byte is taken and every record has come out
  task automatic wait_drained();
    do @(negedge clk_i);
    while (byte_q.size() != 0 || s_axis_tvalid || rec_q.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_list(logic [7:0] vals[$]);
    foreach (vals[i]) begin
      byte_q.insert(byte_q.size(), in_word_t'{data: vals[i], last: (i == vals.size() - 1)});
    end
  endtask

  task automatic queue_random(int unsigned n, logic close);
    for (int unsigned i = 0; i < n; i++) begin
      byte_q.insert(byte_q.size(), in_word_t'{data: 8'($urandom), last: close && (i == n - 1)});
    end
  endtask

  task automatic run_frame(logic pk, int unsigned w, int unsigned h, int unsigned s,
                           logic [7:0] vals[$]);
    set_config(pk, w, h, s);
    queue_list(vals);
    wait_drained();
  endtask

  function automatic int unsigned one_of(int unsigned a, int unsigned b, int unsigned c,
                                         int unsigned d);
    case ($urandom_range(3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  initial begin : stimulus
    int unsigned sent, w, h, s, need, full, n, cut, quiet_end;
    logic        pk;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: a packed 1920-wide frame cut short after two groups
    queue_list('{8'hFF, 8'h00, 8'hAA, 8'h55, 8'hE4, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h1B});
    wait_drained();
    // one-line packed frame, done on the group byte, then an ignored byte
    run_frame(1'b1, 4, 1, 5, '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hE4, 8'h5A});
    // unpacked pairs with one padding byte per line, done on the last padding byte
    run_frame(1'b0, 1, 2, 3, '{8'h34, 8'h12, 8'h00, 8'hCD, 8'hAB, 8'hFF});
    // stride too small, packed then unpacked
    run_frame(1'b1, 4, 1, 4, '{8'h11});
    run_frame(1'b0, 2, 1, 3, '{8'h44});
    // width not a multiple of four, rest of the frame dropped
    run_frame(1'b1, 6, 1, 8, '{8'h22, 8'h33});

    sent      = 0;
    quiet_end = 0;
    while (sent < RandomBytes) begin
      // one stretch of about 80 bytes without idling on either side
      if (quiet_end == 0 && sent >= 120) quiet_end = sent + 80;
      no_idle = (quiet_end != 0 && sent < quiet_end);
      pk = 1'($urandom);
      if ($urandom_range(9) == 0) begin
        // register limits; such frames are always cut short or rejected
        if ($urandom_range(1) == 0) begin
          w = 4096;
          h = 4096;
          s = 8192;
        end else begin
          w = one_of(0, 4096, 8191, $urandom_range(8191));
          h = one_of(0, 1, 4096, 8191);
          s = one_of(0, 1, 8192, 16383);
        end
      end else begin
        w = pk ? 4 * $urandom_range(1, 4) : $urandom_range(1, 8);
        if (pk && $urandom_range(7) == 0) w += $urandom_range(1, 3);
        need = pk ? (w * 5 + 3) / 4 : w * 2;
        s = ($urandom_range(11) == 0) ? need - 1 : need + $urandom_range(0, 3);
        h = $urandom_range(1, 3);
      end
      set_config(pk, w, h, s);
      repeat ($urandom_range(1, 2)) begin
        full = s * h;
        if (full == 0 || full > 300) begin
          n = $urandom_range(1, 40);
        end else if ($urandom_range(4) == 0) begin
          n = $urandom_range(1, full);
        end else begin
          n = full + $urandom_range(0, 3);
        end
        if (n >= 4 && $urandom_range(5) == 0) begin
          // mode flipped partway through the frame
          cut = $urandom_range(1, n - 1);
          queue_random(cut, 1'b0);
          wait_drained();
          cfg_write(CFG_PACKED_MODE, {13'($urandom), !sh_packed});
          @(posedge clk_i);
          cfg_we_i <= 1'b0;
          queue_random(n - cut, 1'b1);
        end else begin
          queue_random(n, 1'b1);
        end
        sent += n;
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
